>>> hw/rtl/kmrd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kmrd_pkg - key matrix row debouncer shared definitions
// Field widths, reset constants and the per-row state record.
// ----------------------------------------------------------------------------
package kmrd_pkg;

    localparam int ROW_W  = 3;   // row index width
    localparam int COL_W  = 16;  // column pattern width
    localparam int TIME_W = 16;  // millisecond time stamp width
    localparam int DEB_W  = 8;   // debounce setting width
    localparam int CNT_W  = 8;   // pressed key count width

    localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 8'd5;

    // State kept for one matrix row
    typedef struct packed {
        logic [COL_W-1:0]  pending;  // last sampled pattern
        logic [TIME_W-1:0] stamp;    // time of the last change
        logic              flag;     // change waiting for commit
        logic [COL_W-1:0]  settled;  // committed pattern
    } row_state_t;

endpackage
`default_nettype wire

>>> hw/rtl/kmrd_row_update.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kmrd_row_update - debounce step for one row
// Applies one sample to a row's state, decides the commit and keeps the
// pressed key total in step with the committed pattern.
// ----------------------------------------------------------------------------
module kmrd_row_update (
    input  wire kmrd_pkg::row_state_t         row_cur,
    input  wire logic [kmrd_pkg::COL_W-1:0]   cols,
    input  wire logic [kmrd_pkg::TIME_W-1:0]  now_ms,
    input  wire logic [kmrd_pkg::DEB_W-1:0]   debounce_ms,
    input  wire logic [kmrd_pkg::CNT_W-1:0]   total_cur,
    output kmrd_pkg::row_state_t              row_next,
    output logic                              committed,
    output logic [kmrd_pkg::CNT_W-1:0]        total_next
);

    function automatic logic [kmrd_pkg::CNT_W-1:0] ones(input logic [kmrd_pkg::COL_W-1:0] v);
        logic [kmrd_pkg::CNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < kmrd_pkg::COL_W; i++)
        begin
            n = n + kmrd_pkg::CNT_W'(v[i]);
        end
        return n;
    endfunction

    logic                        changed;
    logic [kmrd_pkg::TIME_W-1:0] stamp_new;
    logic                        flag_new;
    logic [kmrd_pkg::TIME_W-1:0] elapsed;

    always_comb
    begin
        changed   = (row_cur.pending != cols);
        stamp_new = changed ? now_ms : row_cur.stamp;
        flag_new  = changed | row_cur.flag;
        // wraps modulo 2^16 by width
        elapsed   = now_ms - stamp_new;
        committed = flag_new &&
                    (elapsed > {{(kmrd_pkg::TIME_W-kmrd_pkg::DEB_W){1'b0}}, debounce_ms});

        row_next.pending = cols;
        row_next.stamp   = stamp_new;
        row_next.flag    = flag_new & ~committed;
        row_next.settled = committed ? cols : row_cur.settled;

        // total always equals the sum over settled rows (max 128, never saturates)
        if (committed)
        begin
            total_next = total_cur - ones(row_cur.settled) + ones(cols);
        end
        else
        begin
            total_next = total_cur;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/key_matrix_row_debouncer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// key_matrix_row_debouncer_core - per-row key matrix debouncer
// Takes sampled matrix rows, debounces each row in time and reports the
// committed pattern of the row together with the total of pressed keys.
// ----------------------------------------------------------------------------
// Every input word is one sampled row with its millisecond time. A row whose
// pattern changes is stamped; once the same row is sampled again with more
// than debounce_ms elapsed (modulo 2^16) the pending pattern is committed.
// Each input word yields exactly one output word. Throughput is one word per
// clock when not stalled; each word passes the input register, then the
// result register. The row state update is a single compare, subtract and
// popcount pass between them, so samples of the same row may follow each
// other in consecutive cycles. Rows at or above ROW_COUNT change nothing
// and report a zero pattern; columns at or above COL_COUNT are ignored.
// debounce_ms resets to 5 and must be written only while the block is idle.
// ----------------------------------------------------------------------------
module key_matrix_row_debouncer_core #(
    parameter int ROW_COUNT = 8,   // 1..32
    parameter int COL_COUNT = 16   // 1..32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration: debounce_ms
    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_wdata,
    // input words
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [2:0] row_index, [18:3] column_bits, [34:19] now_ms, [39:35] zero
    input  wire logic [39:0] s_axis_tdata,
    // output words
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [2:0] out_row, [18:3] settled_bits, [19] committed_now,
    // [27:20] pressed_count, [31:28] zero
    output logic [31:0]      m_axis_tdata
);

    // only rows 0..7 can be addressed by the 3-bit index
    localparam int ROWS      = (ROW_COUNT < 8) ? ROW_COUNT : 8;
    localparam int IDX_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int MASK_BITS = (COL_COUNT < kmrd_pkg::COL_W) ? COL_COUNT : kmrd_pkg::COL_W;
    localparam logic [kmrd_pkg::COL_W-1:0] COL_MASK =
        kmrd_pkg::COL_W'((17'(1) << MASK_BITS) - 17'(1));

    // ---- configuration ----
    logic [kmrd_pkg::DEB_W-1:0] debounce_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= kmrd_pkg::DEBOUNCE_RESET;
        end
        else if (cfg_we)
        begin
            debounce_reg <= cfg_wdata;
        end
    end

    // ---- handshake ----
    logic s1_valid_reg;
    logic out_valid_reg;
    logic out_free;
    logic advance;
    logic in_accept;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = s1_valid_reg && out_free;
    assign s_axis_tready = !s1_valid_reg || out_free;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // ---- input register ----
    logic [kmrd_pkg::ROW_W-1:0]  s1_row_reg;
    logic [kmrd_pkg::COL_W-1:0]  s1_cols_reg;
    logic [kmrd_pkg::TIME_W-1:0] s1_now_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_row_reg  <= s_axis_tdata[2:0];
            s1_cols_reg <= s_axis_tdata[18:3] & COL_MASK;
            s1_now_reg  <= s_axis_tdata[34:19];
        end
    end

    // ---- row state ----
    kmrd_pkg::row_state_t       rows_reg [ROWS];
    logic [kmrd_pkg::CNT_W-1:0] total_reg;

    logic                       row_ok;
    logic [IDX_W-1:0]           row_idx;
    kmrd_pkg::row_state_t       row_cur;
    kmrd_pkg::row_state_t       row_next;
    logic                       commit_raw;
    logic [kmrd_pkg::CNT_W-1:0] total_upd;

    assign row_ok  = (32'(s1_row_reg) < ROWS);
    assign row_idx = IDX_W'(s1_row_reg);
    assign row_cur = rows_reg[row_idx];

    kmrd_row_update u_update (
        .row_cur     (row_cur),
        .cols        (s1_cols_reg),
        .now_ms      (s1_now_reg),
        .debounce_ms (debounce_reg),
        .total_cur   (total_reg),
        .row_next    (row_next),
        .committed   (commit_raw),
        .total_next  (total_upd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < ROWS; r++)
            begin
                rows_reg[r] <= '0;
            end
            total_reg <= '0;
        end
        else if (advance && row_ok)
        begin
            rows_reg[row_idx] <= row_next;
            total_reg         <= total_upd;
        end
    end

    // ---- result register ----
    logic [kmrd_pkg::ROW_W-1:0] out_row_reg;
    logic [kmrd_pkg::COL_W-1:0] out_settled_reg;
    logic                       out_commit_reg;
    logic [kmrd_pkg::CNT_W-1:0] out_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_row_reg     <= s1_row_reg;
            out_settled_reg <= row_ok ? row_next.settled : '0;
            out_commit_reg  <= row_ok && commit_raw;
            out_count_reg   <= row_ok ? total_upd : total_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0, out_count_reg, out_commit_reg, out_settled_reg, out_row_reg};

endmodule
`default_nettype wire

>>> tb/sv/key_matrix_row_debouncer_core_tb.sv
// ----------------------------------------------------------------------------
// key_matrix_row_debouncer_core_tb - self-checking bench for the row debouncer
// Streams sampled matrix rows into the core and compares every output word
// field by field with a behavioral model of the per-row debounce state held
// in the bench. Covers the debounce setting at both ends and in between,
// time wrap, bounce and restamp, and commits of an unchanged pattern. Both
// stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module key_matrix_row_debouncer_core_tb;

    import kmrd_pkg::*;

    // Core build under test
    localparam int ROWS = 8;
    localparam int COLS = 16;

    localparam logic [COL_W-1:0] COL_MASK = COL_W'((64'd1 << COLS) - 64'd1);

    // Upper bound on the whole run; far above the slowest legal run
    localparam int RUN_LIMIT = 2_000_000;

    // Cycles past the last output word before the block counts as idle
    // (input register plus result register, with margin)
    localparam int SETTLE_CYCLES = 4;

    // One output word as the core reports it
    typedef struct packed {
        logic [ROW_W-1:0] out_row;
        logic [COL_W-1:0] settled_bits;
        logic             committed_now;
        logic [CNT_W-1:0] pressed_count;
    } row_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [7:0]  cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // [2:0] row_index, [18:3] column_bits, [34:19] now_ms, [39:35] zero
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // [2:0] out_row, [18:3] settled_bits, [19] committed_now,
    // [27:20] pressed_count, [31:28] zero
    logic [31:0] m_axis_tdata;

    key_matrix_row_debouncer_core #(
        .ROW_COUNT(ROWS),
        .COL_COUNT(COLS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Debounce model state, mirrors the core's per-row registers
    // ------------------------------------------------------------------------
    logic [COL_W-1:0]  settled_pattern [ROWS];
    logic [COL_W-1:0]  pending_pattern [ROWS];
    logic [TIME_W-1:0] change_ms       [ROWS];
    logic              change_waiting  [ROWS];
    logic [CNT_W-1:0]  keys_down;
    logic [DEB_W-1:0]  debounce_setting;

    row_result_t expected_results[$];
    int          mismatch_count;

    // Sender burst bookkeeping
    int burst_left;

    // Stimulus side: scan time and the pattern each row is settling toward
    logic [TIME_W-1:0] scan_ms;
    logic [COL_W-1:0]  row_target [ROWS];

    // Receiver stall pattern
    logic [15:0] stall_pattern;
    logic [31:0] stall_cycle;

    // Apply one row sample to the model and return the word the core owes.
    // Only the sampled row is checked for commit; a change restamps the row,
    // so the sample that sets the flag sees zero elapsed time.
    function automatic row_result_t debounce_row_sample(
        input logic [ROW_W-1:0]  row,
        input logic [COL_W-1:0]  cols,
        input logic [TIME_W-1:0] now
    );
        row_result_t       res;
        logic [TIME_W-1:0] elapsed;
        int                total;
        logic [COL_W-1:0]  live_cols;
        res.out_row       = row;
        res.settled_bits  = '0;
        res.committed_now = 1'b0;
        live_cols         = cols & COL_MASK;
        if (row < ROWS) begin
            if (pending_pattern[row] != live_cols) begin
                pending_pattern[row] = live_cols;
                change_ms[row]       = now;
                change_waiting[row]  = 1'b1;
            end
            if (change_waiting[row]) begin
                elapsed = now - change_ms[row];   // modulo 2^16
                if (elapsed > TIME_W'(debounce_setting)) begin
                    settled_pattern[row] = pending_pattern[row];
                    change_waiting[row]  = 1'b0;
                    res.committed_now    = 1'b1;
                    total = 0;
                    for (int r = 0; r < ROWS; r++)
                        total += $countones(settled_pattern[r]);
                    keys_down = (total > 255) ? 8'd255 : CNT_W'(total);
                end
            end
            res.settled_bits = settled_pattern[row];
        end
        res.pressed_count = keys_down;
        return res;
    endfunction

    function automatic void clear_debounce_model();
        for (int r = 0; r < ROWS; r++)
        begin
            settled_pattern[r] = '0;
            pending_pattern[r] = '0;
            change_ms[r]       = '0;
            change_waiting[r]  = 1'b0;
            row_target[r]      = '0;
        end
        keys_down        = '0;
        debounce_setting = DEBOUNCE_RESET;
    endfunction

    // ------------------------------------------------------------------------
    // Sender: one word per call, bursts of random length with random gaps
    // ------------------------------------------------------------------------
    task automatic send_row_sample(
        input logic [ROW_W-1:0]  row,
        input logic [COL_W-1:0]  cols,
        input logic [TIME_W-1:0] now
    );
        int gap;
        if (burst_left == 0) begin
            // a quarter of bursts follow the last one back to back
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, now, cols, row};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        expected_results.push_back(debounce_row_sample(row, cols, now));
    endtask

    // Hold off until every owed word has come out and the pipe is empty
    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // debounce_ms may only change while the core is idle
    task automatic set_debounce(input logic [DEB_W-1:0] setting);
        wait_drained();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= setting;
        @(negedge clk);
        cfg_we    <= 1'b0;
        debounce_setting = setting;
    endtask

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Output checker: every accepted word against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        row_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                $error("output word with no sample owed: 0x%h", m_axis_tdata);
                mismatch_count++;
            end
            else begin
                want = expected_results.pop_front();
                check_field("out_row", want.out_row, m_axis_tdata[2:0]);
                check_field("settled_bits", want.settled_bits, m_axis_tdata[18:3]);
                check_field("committed_now", want.committed_now, m_axis_tdata[19]);
                check_field("pressed_count", want.pressed_count, m_axis_tdata[27:20]);
            end
        end
    end

    // Receiver back-pressure: a 16-bit ready pattern, redrawn whenever stall_cycle[5:0] is zero.
    // Bit 0 is always set so the output never stalls for a full period.
    always @(negedge clk) begin
        if (stall_cycle[5:0] == 6'd0) begin
            case ($urandom_range(0, 2))
                0: stall_pattern = 16'hFFFF;
                1: stall_pattern = 16'($urandom) | 16'h0001;
                default: stall_pattern = 16'($urandom & $urandom) | 16'h0001;
            endcase
        end
        m_axis_tready <= stall_pattern[stall_cycle[3:0]];
        stall_cycle++;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset setting of 5: threshold is strict, bounce restamps, a commit of
    // the already settled pattern still flags, and elapsed time wraps.
    task automatic test_settle_basics();
        send_row_sample(3'd0, 16'h0000, 16'd100);  // matches reset pattern
        send_row_sample(3'd7, 16'hFFFF, 16'd100);  // change, zero elapsed
        send_row_sample(3'd7, 16'hFFFF, 16'd105);  // equal to setting: hold
        send_row_sample(3'd7, 16'hFFFF, 16'd106);  // one past: commit
        send_row_sample(3'd3, 16'h0001, 16'd200);
        send_row_sample(3'd3, 16'h8000, 16'd203);  // bounce restamps
        send_row_sample(3'd3, 16'h8000, 16'd208);  // 5 since restamp: hold
        send_row_sample(3'd3, 16'h8000, 16'd209);  // commit
        send_row_sample(3'd3, 16'h0000, 16'd300);  // glitch away...
        send_row_sample(3'd3, 16'h8000, 16'd302);  // ...and back
        send_row_sample(3'd3, 16'h8000, 16'd310);  // commits same pattern
        send_row_sample(3'd5, 16'h5A5A, 16'hFFFE);
        send_row_sample(3'd5, 16'h5A5A, 16'h0004); // wraps, elapsed 6
    endtask

    // Zero setting: the changing sample never commits itself; a later one does once the time has moved on
    task automatic test_zero_debounce();
        set_debounce(8'd0);
        send_row_sample(3'd1, 16'hAAAA, 16'h1234);
        send_row_sample(3'd1, 16'hAAAA, 16'h1234);
        send_row_sample(3'd1, 16'hAAAA, 16'h1235);
    endtask

    // Largest setting across the time wrap
    task automatic test_max_debounce();
        set_debounce(8'd255);
        send_row_sample(3'd2, 16'h7FFF, 16'hFF00);
        send_row_sample(3'd2, 16'h7FFF, 16'hFFFF); // elapsed 255: hold
        send_row_sample(3'd2, 16'h7FFF, 16'h0000); // elapsed 256: commit
    endtask

    function automatic logic [COL_W-1:0] pick_row_pattern();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return COL_W'(1) << $urandom_range(0, COL_W - 1);
            default: return COL_W'($urandom);
        endcase
    endfunction

    // Scanner-like traffic: rows mostly settle on a target, with bounce,
    // new key patterns and the odd jump of the clock
    task automatic test_random_scan(input int words, input logic [DEB_W-1:0] setting);
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] cols;
        int               roll;
        set_debounce(setting);
        for (int i = 0; i < words; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 2)
                scan_ms = TIME_W'($urandom);
            else
                scan_ms += TIME_W'($urandom_range(0, setting / 4 + 2));
            row  = ROW_W'($urandom_range(0, ROWS - 1));
            roll = $urandom_range(0, 99);
            if (roll < 12) begin
                row_target[row] = pick_row_pattern();
                cols = row_target[row];
            end
            else if (roll < 27) begin
                // contact bounce: a few columns flicker
                cols = row_target[row] ^ ((COL_W'(1) << $urandom_range(0, COL_W - 1))
                                          | COL_W'($urandom & $urandom & $urandom));
            end
            else begin
                cols = row_target[row];
            end
            if ($urandom_range(0, 299) == 0)
                wait_drained();
            send_row_sample(row, cols, scan_ms);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        m_axis_tready  = 1'b0;
        stall_pattern  = 16'hFFFF;
        stall_cycle    = '0;
        burst_left     = 0;
        mismatch_count = 0;
        scan_ms        = TIME_W'($urandom);
        clear_debounce_model();

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        test_settle_basics();
        test_zero_debounce();
        test_max_debounce();
        test_random_scan(300, DEBOUNCE_RESET);
        test_random_scan(250, 8'd1);
        test_random_scan(200, 8'd20);
        test_random_scan(150, 8'd255);
        test_random_scan(150, DEB_W'($urandom_range(0, 255)));
        test_random_scan(150, 8'd0);

        wait_drained();
        repeat (10) @(negedge clk);
        if (expected_results.size() != 0) begin
            $error("%0d output words never arrived", expected_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog
    initial begin
        #(RUN_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/kmrd_pkg.sv
hw/rtl/kmrd_row_update.sv
hw/rtl/key_matrix_row_debouncer_core.sv
tb/sv/key_matrix_row_debouncer_core_tb.sv
